>>> sv/ctdl_pkg.sv
// ----------------------------------------------------------------------------
// ctdl_pkg: shared definitions for the critic network TD learner
// Holds the default sizes, the mode and register codes, the rounding and
// saturation helpers and the sigmoid table entry function.
// ----------------------------------------------------------------------------
package ctdl_pkg;

  // Default sizes of the network and of the activation table.
  localparam int unsigned CTDL_HIDDEN_UNITS = 4;
  localparam int unsigned CTDL_SIG_DEPTH    = 256;

  // Fixed field widths.
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned WGT_W  = 24;
  localparam int unsigned PROD_W = 57;

  // Reset values of the configuration registers.
  localparam logic [15:0] LR_RESET   = 16'd26214;
  localparam logic [15:0] DISC_RESET = 16'd62259;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_EVAL   = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_NOP    = 2'd3
  } ctdl_mode_e;

  // Configuration register indexes.
  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_DISCOUNT      = 1'b1;

  typedef logic signed [PROD_W-1:0] prod_t;

  // Round half up by n fraction bits.
  function automatic prod_t ctdl_rnd(input prod_t v, input int unsigned n);
    prod_t half;
    half = prod_t'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  // Saturate to a 24-bit signed weight.
  function automatic logic signed [WGT_W-1:0] ctdl_sat_w(input prod_t v);
    if (v < -prod_t'(64'sd8388608)) begin
      return -24'sd8388608;
    end else if (v > prod_t'(64'sd8388607)) begin
      return 24'sd8388607;
    end
    return v[WGT_W-1:0];
  endfunction

  // Saturate to a 16-bit signed value.
  function automatic logic signed [VAL_W-1:0] ctdl_sat16(input prod_t v);
    if (v < -prod_t'(64'sd32768)) begin
      return -16'sd32768;
    end else if (v > prod_t'(64'sd32767)) begin
      return 16'sd32767;
    end
    return v[VAL_W-1:0];
  endfunction

  // Unsigned quotient by shift and subtract. Evaluated at elaboration only.
  function automatic logic [63:0] ctdl_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One entry of the bipolar sigmoid table, tanh(u/2) in Q10, from the
  // table position y in Q30. Evaluated at elaboration only.
  function automatic logic [15:0] ctdl_sig_entry(input logic [63:0] y);
    logic [63:0] one;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    one = 64'd1 << 30;
    y2  = (y * y) >> 30;
    y3  = (y2 * y) >> 30;
    e   = one - y + (y2 >> 1) - ctdl_udiv(y3, 64'd6);
    for (int r = 0; r < 8; r++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    if (e > one) begin
      e = one;
    end
    num = ((one - e) << 10) + ((one + e) >> 1);
    den = one + e;
    quo = ctdl_udiv(num, den);
    return quo[15:0];
  endfunction

endpackage

>>> sv/critic_network_td_learner_top.sv
// ----------------------------------------------------------------------------
// critic_network_td_learner_top: online critic network with TD learning
// A 3-input, HIDDEN_UNITS-hidden, 1-output fixed-point network. The weights
// live in one synchronous memory; one shared multiplier works through them.
//
// Usage: each input word carries a mode. Evaluate stores the inputs and
// computes the cost, update forms the temporal error and trains every
// weight, load writes one weight. Every accepted word yields exactly one
// output word with the latest cost and the temporal error (zero unless the
// word was an update). Configuration writes (learning rate, discount) are
// taken at any time on their own channel and are always ready.
// The processing time is set by the single shared multiplier (registered)
// and the one read port of the weight memory. One word is processed at a
// time.
// Reset clears all weights (by per-entry valid bits, no clearing pass), the
// stored inputs, activations and cost, and loads the default learning rate
// and discount. The output sits in a register: while the receiver stalls the
// next word can still be accepted and processed; it waits in its last cycle
// until the output register is free.
// ----------------------------------------------------------------------------
module critic_network_td_learner_top #(
  parameter int unsigned HIDDEN_UNITS        = ctdl_pkg::CTDL_HIDDEN_UNITS,
  parameter int unsigned SIGMOID_TABLE_DEPTH = ctdl_pkg::CTDL_SIG_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic signed [15:0]  tracking_error_i,
  input  logic signed [15:0]  error_rate_i,
  input  logic signed [15:0]  steer_command_i,
  input  logic signed [15:0]  cost_now_i,
  input  logic signed [15:0]  reference_i,
  input  logic [3:0]          weight_index_i,
  input  logic signed [23:0]  weight_value_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [14:0]         cost_estimate_o,
  output logic signed [15:0]  temporal_error_o,
  // Configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import ctdl_pkg::*;

  localparam int unsigned H      = HIDDEN_UNITS;
  localparam int unsigned D      = SIGMOID_TABLE_DEPTH;
  localparam int unsigned NW     = 4 * H;
  localparam int unsigned AW     = $clog2(NW);
  localparam int unsigned JW     = (H > 1) ? $clog2(H) : 1;
  localparam int unsigned IW     = $clog2(D);
  localparam int unsigned ACC_W  = 48;

  typedef enum logic [4:0] {
    S_IDLE, S_EV_RD, S_EV_OP, S_EV_ACC, S_L2_RD, S_L2_OP, S_L2_ACC,
    S_UP_E, S_UP_V, S_UP_S, S_UP_J_RD, S_UP_J_OLD, S_UP_T, S_UP_U, S_UP_P,
    S_UP_K_RD, S_UP_K_WR, S_UP_W2, S_MUL, S_DONE
  } state_e;

  // Sigmoid table, built at elaboration.
  logic [15:0] sig_tbl [D];
  for (genvar i = 0; i < D; i++) begin : g_tbl
    localparam logic [63:0] Y   = (64'(i) << 25) / SIGMOID_TABLE_DEPTH;
    localparam logic [15:0] VAL = ctdl_sig_entry(Y);
    assign sig_tbl[i] = VAL;
  end

  state_e                    state_q, ret_q;
  logic [15:0]               lr_q, disc_q;
  logic signed [VAL_W-1:0]   x_q [3];
  logic signed [VAL_W-1:0]   h_q [H];
  logic [14:0]               last_cost_q;
  logic signed [VAL_W-1:0]   te_q, ref_q;
  logic [1:0]                k_q;
  logic [JW-1:0]             j_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [31:0]        mul_a_q;
  logic signed [24:0]        mul_b_q;
  prod_t                     prod_q;
  logic signed [17:0]        s_q;
  logic signed [24:0]        t_q;
  logic signed [31:0]        p_q;
  logic signed [WGT_W-1:0]   old_q;
  logic                      out_valid_q;
  logic [14:0]               cost_out_q;
  logic signed [VAL_W-1:0]   te_out_q;

  // Weight memory, valid bits and read data.
  logic [WGT_W-1:0]          wmem [NW];
  logic [NW-1:0]             wvalid_q;
  logic [WGT_W-1:0]          rdata_q;
  logic                      rvalid_q;
  logic                      rd_en, wr_en;
  logic [AW-1:0]             rd_addr, wr_addr, l1_addr, l2_addr;
  logic signed [WGT_W-1:0]   wr_data, rword;

  logic                      in_acc, last_j;
  logic signed [ACC_W-1:0]   acc_sum, hq, cq;
  logic [ACC_W-1:0]          hq_abs;
  logic [25:0]               tidx_wide;
  logic [IW-1:0]             tidx;
  logic signed [VAL_W-1:0]   act;
  logic [14:0]               cost_sat;
  prod_t                     rnd4, rnd10, rnd16, rnd_t;
  logic signed [VAL_W-1:0]   e_sat;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign last_j      = (j_q == JW'(H - 1));
  assign rword       = rvalid_q ? $signed(rdata_q) : '0;

  assign l1_addr = AW'(AW'(k_q) * AW'(H) + AW'(j_q));
  assign l2_addr = AW'(3 * H) + AW'(j_q);

  // Memory access control.
  always_comb begin
    rd_en   = (state_q == S_EV_RD) || (state_q == S_L2_RD) ||
              (state_q == S_UP_J_RD) || (state_q == S_UP_K_RD);
    rd_addr = ((state_q == S_L2_RD) || (state_q == S_UP_J_RD)) ? l2_addr : l1_addr;
    wr_en   = 1'b0;
    wr_addr = l1_addr;
    wr_data = weight_value_i;
    if (in_acc && (mode_i == MODE_LOAD) && ({28'b0, weight_index_i} < 32'(NW))) begin
      wr_en   = 1'b1;
      wr_addr = AW'(weight_index_i);
    end else if (state_q == S_UP_K_WR) begin
      wr_en   = 1'b1;
      wr_data = ctdl_sat_w(PROD_W'(rword) - rnd10);
    end else if (state_q == S_UP_W2) begin
      wr_en   = 1'b1;
      wr_addr = l2_addr;
      wr_data = ctdl_sat_w(PROD_W'(old_q) - rnd4);
    end
  end

  // Weight storage: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= wmem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rvalid_q <= wvalid_q[rd_addr];
      end
      if (wr_en) begin
        wvalid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
  end

  // Rounded forms of the product and the temporal error.
  always_comb begin
    rnd4  = ctdl_rnd(prod_q, 4);
    rnd10 = ctdl_rnd(prod_q, 10);
    rnd16 = ctdl_rnd(prod_q, 16);
    rnd_t = ctdl_rnd(PROD_W'(64'sd1048576) - prod_q, 11);
    e_sat = ctdl_sat16(rnd16 - PROD_W'(ref_q));
  end

  // Activation through the sigmoid table and cost clamp.
  always_comb begin
    acc_sum   = acc_q + $signed(prod_q[ACC_W-1:0]);
    hq        = (acc_sum + 48'sd32768) >>> 16;
    hq_abs    = hq[ACC_W-1] ? 48'(-hq) : 48'(hq);
    tidx_wide = (26'(hq_abs[12:0]) * 26'(D)) >> 13;
    if ((hq_abs >= 48'd8192) || (tidx_wide > 26'(D - 1))) begin
      tidx = IW'(D - 1);
    end else begin
      tidx = tidx_wide[IW-1:0];
    end
    act = $signed(sig_tbl[tidx]);
    if (acc_sum < 0) begin
      act = -act;
    end
    if ((sig_tbl[tidx] == 16'd0) && (acc_sum != 0)) begin
      act = (acc_sum < 0) ? -16'sd1 : 16'sd1;
    end
    cq = hq;
    if (cq < 0) begin
      cost_sat = '0;
    end else if (cq > 48'sd32767) begin
      cost_sat = 15'h7FFF;
    end else begin
      cost_sat = cq[14:0];
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      lr_q        <= LR_RESET;
      disc_q      <= DISC_RESET;
      x_q         <= '{default: '0};
      h_q         <= '{default: '0};
      last_cost_q <= '0;
      te_q        <= '0;
      ref_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      acc_q       <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      s_q         <= '0;
      t_q         <= '0;
      p_q         <= '0;
      old_q       <= '0;
      out_valid_q <= 1'b0;
      cost_out_q  <= '0;
      te_out_q    <= '0;
    end else begin
      // Configuration writes.
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_LEARNING_RATE: lr_q   <= cfg_data_i;
          CFG_DISCOUNT:      disc_q <= cfg_data_i;
          default:           lr_q   <= lr_q;
        endcase
      end

      // The final state handles the output register on its own.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            te_q <= '0;
            k_q  <= '0;
            j_q  <= '0;
            unique case (ctdl_mode_e'(mode_i))
              MODE_EVAL: begin
                x_q[0]  <= tracking_error_i;
                x_q[1]  <= error_rate_i;
                x_q[2]  <= steer_command_i;
                acc_q   <= '0;
                state_q <= S_EV_RD;
              end
              MODE_UPDATE: begin
                ref_q   <= reference_i;
                mul_a_q <= {16'b0, disc_q};
                mul_b_q <= 25'(cost_now_i);
                ret_q   <= S_UP_E;
                state_q <= S_MUL;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_MUL: state_q <= ret_q;
        // First layer: sum of input times weight per hidden unit.
        S_EV_RD: state_q <= S_EV_OP;
        S_EV_OP: begin
          mul_a_q <= 32'(x_q[k_q]);
          mul_b_q <= 25'(rword);
          ret_q   <= S_EV_ACC;
          state_q <= S_MUL;
        end
        S_EV_ACC: begin
          if (k_q == 2'd2) begin
            h_q[j_q] <= act;
            acc_q    <= '0;
            k_q      <= '0;
            if (last_j) begin
              j_q     <= '0;
              state_q <= S_L2_RD;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_EV_RD;
            end
          end else begin
            acc_q   <= acc_sum;
            k_q     <= k_q + 1'b1;
            state_q <= S_EV_RD;
          end
        end
        // Second layer: cost from the activations.
        S_L2_RD: state_q <= S_L2_OP;
        S_L2_OP: begin
          mul_a_q <= 32'(h_q[j_q]);
          mul_b_q <= 25'(rword);
          ret_q   <= S_L2_ACC;
          state_q <= S_MUL;
        end
        S_L2_ACC: begin
          if (last_j) begin
            last_cost_q <= cost_sat;
            state_q     <= S_DONE;
          end else begin
            acc_q   <= acc_sum;
            j_q     <= j_q + 1'b1;
            state_q <= S_L2_RD;
          end
        end
        // Update: temporal error and common step.
        S_UP_E: begin
          te_q    <= e_sat;
          mul_a_q <= {16'b0, disc_q};
          mul_b_q <= 25'(e_sat);
          ret_q   <= S_UP_V;
          state_q <= S_MUL;
        end
        S_UP_V: begin
          mul_a_q <= rnd16[31:0];
          mul_b_q <= {9'b0, lr_q};
          ret_q   <= S_UP_S;
          state_q <= S_MUL;
        end
        S_UP_S: begin
          s_q     <= rnd16[17:0];
          state_q <= S_UP_J_RD;
        end
        // Per hidden unit: backpropagated factor.
        S_UP_J_RD: state_q <= S_UP_J_OLD;
        S_UP_J_OLD: begin
          old_q   <= rword;
          mul_a_q <= 32'(h_q[j_q]);
          mul_b_q <= 25'(h_q[j_q]);
          ret_q   <= S_UP_T;
          state_q <= S_MUL;
        end
        S_UP_T: begin
          t_q     <= rnd_t[24:0];
          mul_a_q <= 32'(s_q);
          mul_b_q <= 25'(old_q);
          ret_q   <= S_UP_U;
          state_q <= S_MUL;
        end
        S_UP_U: begin
          mul_a_q <= rnd10[31:0];
          mul_b_q <= t_q;
          ret_q   <= S_UP_P;
          state_q <= S_MUL;
        end
        S_UP_P: begin
          p_q     <= rnd10[31:0];
          k_q     <= '0;
          state_q <= S_UP_K_RD;
        end
        // First-layer weights of this unit, one per input.
        S_UP_K_RD: begin
          mul_a_q <= p_q;
          mul_b_q <= 25'(x_q[k_q]);
          ret_q   <= S_UP_K_WR;
          state_q <= S_MUL;
        end
        S_UP_K_WR: begin
          if (k_q == 2'd2) begin
            mul_a_q <= 32'(s_q);
            mul_b_q <= 25'(h_q[j_q]);
            ret_q   <= S_UP_W2;
            state_q <= S_MUL;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_UP_K_RD;
          end
        end
        S_UP_W2: begin
          if (last_j) begin
            j_q     <= '0;
            state_q <= S_DONE;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_UP_J_RD;
          end
        end
        // Hand the word to the output register once it is free.
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            cost_out_q  <= last_cost_q;
            te_out_q    <= te_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cost_estimate_o  = cost_out_q;
  assign temporal_error_o = te_out_q;

  // A weight is never written and read at the same address in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("weight memory read and write collide");

  // New output words only come from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output word raised outside the final state");

  // The input counter never reaches a fourth input.
  assert property (@(posedge clk_i) disable iff (!rst_ni) k_q != 2'd3)
    else $error("input counter out of range");

  // The unit counter stays within the hidden layer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) j_q <= JW'(H - 1))
    else $error("unit counter out of range");

endmodule

>>> verif/tb_critic_network_td_learner_top.sv
// ----------------------------------------------------------------------------
// tb_critic_network_td_learner_top: self-checking bench for the critic network
// Drives evaluate, update, load and no-op words through the input channel and
// checks every output word against a bit-exact predictor of the network. The
// learning rate and discount are changed between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_critic_network_td_learner_top;
  import ctdl_pkg::*;

  localparam int H     = 4;
  localparam int DEPTH = 256;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] te;
    logic signed [15:0] er;
    logic signed [15:0] sc;
    logic signed [15:0] cn;
    logic signed [15:0] rf;
    logic [3:0]         wi;
    logic signed [23:0] wv;
  } net_word_t;

  typedef struct packed {
    logic [14:0]        cost;
    logic signed [15:0] terr;
  } net_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic signed [15:0] tracking_error_i = '0, error_rate_i = '0, steer_command_i = '0;
  logic signed [15:0] cost_now_i = '0, reference_i = '0;
  logic [3:0] weight_index_i = '0;
  logic signed [23:0] weight_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [14:0] cost_estimate_o;
  logic signed [15:0] temporal_error_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  critic_network_td_learner_top dut (.*);

  // Clock and cycle counter.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int cycles = 0;
  always @(posedge clk_i) cycles <= cycles + 1;

  // Predictor state.
  logic [15:0] sig_lut [DEPTH];
  logic [15:0] pred_lr, pred_disc;
  longint w1 [3*H];
  longint w2 [H];
  longint xin [3];
  longint hact [H];
  longint cost_reg;

  net_word_t   word_queue[$];
  net_result_t result_queue[$];
  int mismatches = 0;
  int results_seen = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  bit in_taken = 1'b0;

  function automatic longint round_half(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Build the sigmoid magnitude table the same way the block does.
  task automatic build_sigmoid;
    longint unsigned one, y, y2, y3, e;
    one = 64'd1 << 30;
    for (int i = 0; i < DEPTH; i++) begin
      y  = (longint'(i) << 25) / DEPTH;
      y2 = (y * y) >> 30;
      y3 = (y2 * y) >> 30;
      e  = one - y + y2 / 2 - y3 / 6;
      for (int r = 0; r < 8; r++) e = (e * e + (64'd1 << 29)) >> 30;
      if (e > one) e = one;
      sig_lut[i] = 16'((((one - e) << 10) + (one + e) / 2) / (one + e));
    end
  endtask

  // Advance the network model by one word and return its output word.
  function automatic net_result_t network_step(net_word_t w);
    net_result_t r;
    longint acc, hq, a, idx, v, acc2, e, s, old, t, p, d;
    r.terr = '0;
    if (w.mode == MODE_EVAL) begin
      xin[0] = w.te; xin[1] = w.er; xin[2] = w.sc;
      for (int j = 0; j < H; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += xin[k] * w1[k*H+j];
        hq = round_half(acc, 16);
        a = hq < 0 ? -hq : hq;
        idx = (a >= 8192) ? DEPTH - 1 : (a * DEPTH) / 8192;
        if (idx > DEPTH - 1) idx = DEPTH - 1;
        v = sig_lut[idx];
        if (acc < 0) v = -v;
        if (v == 0 && acc != 0) v = acc > 0 ? 1 : -1;
        hact[j] = v;
      end
      acc2 = 0;
      for (int j = 0; j < H; j++) acc2 += hact[j] * w2[j];
      cost_reg = clip(round_half(acc2, 16), 0, 32767);
    end else if (w.mode == MODE_UPDATE) begin
      e = clip(round_half(longint'(pred_disc) * w.cn, 16) - w.rf, -32768, 32767);
      r.terr = 16'(e);
      s = round_half(round_half(longint'(pred_disc) * e, 16) * longint'(pred_lr), 16);
      for (int j = 0; j < H; j++) begin
        old = w2[j];
        t = round_half((longint'(1) << 20) - hact[j] * hact[j], 11);
        p = round_half(round_half(s * old, 10) * t, 10);
        for (int k = 0; k < 3; k++) begin
          d = round_half(p * xin[k], 10);
          w1[k*H+j] = clip(w1[k*H+j] - d, -8388608, 8388607);
        end
        w2[j] = clip(old - round_half(s * hact[j], 4), -8388608, 8388607);
      end
    end else if (w.mode == MODE_LOAD) begin
      if (w.wi < 3*H) w1[w.wi] = w.wv;
      else if (w.wi < 4*H) w2[w.wi - 3*H] = w.wv;
    end
    r.cost = 15'(cost_reg);
    return r;
  endfunction

  // Input acceptance as seen at the rising edge.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // Driver: offer queued words, with random gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        result_queue.push_back(network_step(word_queue.pop_front()));
      end
      if (!in_valid_i || in_taken) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i       <= 1'b1;
          mode_i           <= word_queue[0].mode;
          tracking_error_i <= word_queue[0].te;
          error_rate_i     <= word_queue[0].er;
          steer_command_i  <= word_queue[0].sc;
          cost_now_i       <= word_queue[0].cn;
          reference_i      <= word_queue[0].rf;
          weight_index_i   <= word_queue[0].wi;
          weight_value_i   <= word_queue[0].wv;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Long receiver stall, counted down in cycles.
  always @(negedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // Monitor: compare each output word with the oldest expected one.
  always @(posedge clk_i) begin
    net_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (result_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("ERROR: unexpected output word at cycle %0d", cycles);
      end else begin
        exp_r = result_queue.pop_front();
        if (exp_r.cost !== cost_estimate_o || exp_r.terr !== temporal_error_o) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("ERROR: cost exp %0d got %0d, td error exp %0d got %0d",
                     exp_r.cost, cost_estimate_o, exp_r.terr, temporal_error_o);
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($signed(16'($urandom_range(8191))) - 16'sd4096);
    endcase
  endfunction

  function automatic net_word_t make_word(logic [1:0] m);
    net_word_t w;
    w.mode = m;
    w.te = rand_val(); w.er = rand_val(); w.sc = rand_val();
    w.cn = rand_val(); w.rf = rand_val();
    w.wi = 4'($urandom);
    w.wv = ($urandom_range(3) == 0) ? 24'($urandom)
                                    : 24'($signed(24'($urandom_range(262143))) - 24'sd131072);
    return w;
  endfunction

  // Wait until every queued word has been answered.
  task automatic drain;
    while (word_queue.size() > 0 || result_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_LEARNING_RATE) pred_lr = val; else pred_disc = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly load weights, evaluate and update, some noise.
  task automatic random_phase(int n);
    net_word_t w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1:    word_queue.push_back(make_word(MODE_LOAD));
        2, 3, 4: word_queue.push_back(make_word(MODE_EVAL));
        5, 6, 7: word_queue.push_back(make_word(MODE_UPDATE));
        8:       word_queue.push_back(make_word(MODE_NOP));
        default: begin
          w = make_word(MODE_LOAD);
          w.wi = 4'(12 + $urandom_range(3));
          word_queue.push_back(w);
        end
      endcase
    end
  endtask

  initial begin
    net_word_t w;
    build_sigmoid();
    pred_lr = LR_RESET; pred_disc = DISC_RESET;
    foreach (w1[i]) w1[i] = 0;
    foreach (w2[i]) w2[i] = 0;
    foreach (hact[i]) hact[i] = 0;
    foreach (xin[i]) xin[i] = 0;
    cost_reg = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed words: update before any evaluation, nop, extreme weights
    // and inputs, tiny activation.
    w = make_word(MODE_UPDATE); w.cn = 16'sh7fff; w.rf = 16'sh8000; word_queue.push_back(w);
    word_queue.push_back(make_word(MODE_NOP));
    for (int i = 0; i < 16; i++) begin
      w = make_word(MODE_LOAD); w.wi = 4'(i);
      w.wv = (i % 2) ? 24'sh7fffff : 24'sh800000;
      if (i == 0) w.wv = 24'sd1;
      word_queue.push_back(w);
    end
    w = make_word(MODE_EVAL); w.te = 16'sh7fff; w.er = 16'sh8000; w.sc = 16'sh7fff;
    word_queue.push_back(w);
    w = make_word(MODE_EVAL); w.te = 16'sd1; w.er = 0; w.sc = 0; word_queue.push_back(w);
    w = make_word(MODE_UPDATE); w.cn = 16'sh8000; w.rf = 16'sh7fff; word_queue.push_back(w);
    w = make_word(MODE_EVAL); w.te = 16'sh8000; w.er = 16'sh8000; w.sc = 16'sh8000;
    word_queue.push_back(w);
    drain();

    // Phases over the idling styles and register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 63; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 63; end
        default: begin send_idle = 11; recv_idle = 11; end
      endcase
      write_reg(CFG_LEARNING_RATE, ph == 0 ? 16'hffff : (ph == 1 ? 16'h0000 : 16'($urandom)));
      write_reg(CFG_DISCOUNT, ph == 0 ? 16'h0000 : (ph == 1 ? 16'hffff : 16'($urandom)));
      if (ph == 2) hold_off = 600;
      random_phase(290);
      drain();
    end
    send_idle = 0; recv_idle = 0;
    write_reg(CFG_LEARNING_RATE, LR_RESET);
    write_reg(CFG_DISCOUNT, DISC_RESET);
    random_phase(20);
    drain();

    $display("Run covered %0d output words over four idling phases and five register settings.",
             results_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ctdl_pkg.sv
sv/critic_network_td_learner_top.sv
verif/tb_critic_network_td_learner_top.sv
